/* design/cdtp_pkg.sv */
// Shared constants and helper functions for the cookie date token parser.
`timescale 1ns / 1ps
`default_nettype none
package cdtp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned VAL_W     = 7;
    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned NDC_W     = 3;
    localparam int unsigned TDATA_IN  = 8;
    localparam int unsigned TDATA_OUT = 48;

    // time token phases
    localparam logic [PHASE_W-1:0] PH_HOUR = 3'd0;
    localparam logic [PHASE_W-1:0] PH_MIN  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SEC  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_OK   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_FAIL = 3'd4;

    // found flag bits
    localparam int unsigned FND_TIME  = 0;
    localparam int unsigned FND_DAY   = 1;
    localparam int unsigned FND_MONTH = 2;
    localparam int unsigned FND_YEAR  = 3;

    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

    localparam logic [YEAR_W-1:0] YEAR_MIN     = 14'd1601;
    localparam logic [YEAR_W-1:0] YEAR_TWO_LIM = 14'd100;
    localparam logic [YEAR_W-1:0] YEAR_PIVOT   = 14'd70;
    localparam logic [YEAR_W-1:0] YEAR_BASE_20 = 14'd2000;
    localparam logic [YEAR_W-1:0] YEAR_BASE_19 = 14'd1900;

    function automatic logic is_delim(input logic [BYTE_W-1:0] c);
        return c inside {8'h09, [8'h20:8'h2F], [8'h3B:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
    endfunction

    // lowercased three-letter prefix to month number, 0 when no match
    function automatic logic [MONTH_W-1:0] month_code(input logic [23:0] w);
        logic [MONTH_W-1:0] m;
        case (w)
            "jan":   m = 4'd1;
            "feb":   m = 4'd2;
            "mar":   m = 4'd3;
            "apr":   m = 4'd4;
            "may":   m = 4'd5;
            "jun":   m = 4'd6;
            "jul":   m = 4'd7;
            "aug":   m = 4'd8;
            "sep":   m = 4'd9;
            "oct":   m = 4'd10;
            "nov":   m = 4'd11;
            "dec":   m = 4'd12;
            default: m = 4'd0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

/* design/cookie_date_token_parser.sv */
// Top level: byte-serial cookie date parser with registered input and result.
`timescale 1ns / 1ps
`default_nettype none
// Cookie date parser (RFC 6265 5.1.1). Takes one date-string byte per item on
// the s_ side, tlast on the final byte, and gives one result item per string on
// the m_ side. Bytes are split at delimiter bytes into tokens; each token is tried
// as time, day, month, then year, each kind taken once. The result carries a
// valid flag and the fields (two-digit years fixed up), or all zeros when the
// date is invalid; the parser then starts fresh. Rate: one byte per clock, as
// long as no last byte is held. A byte lands in an input register, and then the
// token state is updated from it by one shallow pass of logic; the result
// register loads on the edge that updates the state with the last byte, and
// m_tvalid rises with it. Ready only drops when a last byte sits in the input
// register while the previous result is still waiting on m_tready.
module cookie_date_token_parser
    import cdtp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [TDATA_IN-1:0]  s_tdata,   // [7:0] char_byte
    input  wire logic                 s_tlast,   // last_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [TDATA_OUT-1:0]      m_tdata    // [0] date_valid, [14:1] year_out,
                                                 // [18:15] month_out, [23:19] day_out,
                                                 // [28:24] hour_out, [34:29] minute_out,
                                                 // [40:35] second_out, [47:41] zero
);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // parse state
    logic [3:0]         found_reg,   found_next;
    logic [VAL_W-1:0]   hour_reg,    hour_next;
    logic [VAL_W-1:0]   minute_reg,  minute_next;
    logic [VAL_W-1:0]   second_reg,  second_next;
    logic [VAL_W-1:0]   day_reg,     day_next;
    logic [MONTH_W-1:0] month_reg,   month_next;
    logic [YEAR_W-1:0]  year_reg,    year_next;
    logic [1:0]         tpos_reg,    tpos_next;
    logic               in_tok_reg,  in_tok_next;
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic [1:0]         tdc_reg,     tdc_next;
    logic [YEAR_W-1:0]  acc_reg,     acc_next;
    logic [NDC_W-1:0]   ndc_reg,     ndc_next;
    logic               nstop_reg,   nstop_next;
    logic [23:0]        letters_reg, letters_next;

    // result register
    logic                 out_valid_reg;
    logic [TDATA_OUT-1:0] out_data_reg, out_data_next;

    logic slot_free;
    logic advance;

    assign slot_free = !out_valid_reg || m_tready;
    // a last byte needs room in the result register, other bytes never stall
    assign advance   = in_valid_reg && (!in_last_reg || slot_free);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb begin : step_logic
        logic [BYTE_W-1:0]  c;
        logic               dig;
        logic [3:0]         d;
        logic [VAL_W-1:0]   slot;
        logic               time_ok;
        logic               day_ok;
        logic               year_ok;
        logic [MONTH_W-1:0] mon;
        logic [YEAR_W-1:0]  yfix;
        logic               ok;

        found_next   = found_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        tpos_next    = tpos_reg;
        in_tok_next  = in_tok_reg;
        phase_next   = phase_reg;
        tdc_next     = tdc_reg;
        acc_next     = acc_reg;
        ndc_next     = ndc_reg;
        nstop_next   = nstop_reg;
        letters_next = letters_reg;
        slot         = '0;

        c   = in_byte_reg;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d   = c[3:0];

        // token byte
        if (!is_delim(c)) begin
            in_tok_next = 1'b1;
            if (tpos_reg != 2'd3) begin
                letters_next = {letters_reg[15:0],
                                ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c + CASE_OFS) : c};
                tpos_next    = tpos_reg + 2'd1;
            end
            // leading digit run, only the first four digits accumulate
            if (!nstop_reg) begin
                if (dig) begin
                    if (ndc_reg < NDC_W'(5)) begin
                        ndc_next = ndc_reg + NDC_W'(1);
                    end
                    if (ndc_next <= NDC_W'(4)) begin
                        acc_next = {acc_reg[YEAR_W-4:0], 3'b000} + {acc_reg[YEAR_W-2:0], 1'b0}
                                 + YEAR_W'(d);
                    end
                end else begin
                    nstop_next = 1'b1;
                end
            end
            // h:m:s matcher
            if (!found_reg[FND_TIME] && (phase_reg < PH_OK)) begin
                if (dig) begin
                    if (tdc_reg >= 2'd2) begin
                        phase_next = PH_FAIL;
                    end else begin
                        case (phase_reg)
                            PH_HOUR: slot = hour_reg;
                            PH_MIN:  slot = minute_reg;
                            default: slot = second_reg;
                        endcase
                        if (tdc_reg == 2'd0) begin
                            slot = VAL_W'(d);
                        end else begin
                            slot = {slot[3:0], 3'b000} + {slot[5:0], 1'b0} + VAL_W'(d);
                        end
                        case (phase_reg)
                            PH_HOUR: hour_next   = slot;
                            PH_MIN:  minute_next = slot;
                            default: second_next = slot;
                        endcase
                        tdc_next = tdc_reg + 2'd1;
                    end
                end else if (tdc_reg == 2'd0) begin
                    phase_next = PH_FAIL;
                end else if (phase_reg == PH_SEC) begin
                    phase_next = PH_OK;
                end else if (c == CH_COLON) begin
                    phase_next = phase_reg + PHASE_W'(1);
                    tdc_next   = 2'd0;
                end else begin
                    phase_next = PH_FAIL;
                end
            end
        end

        // token end: at a delimiter, or at the last byte
        time_ok = (phase_next == PH_OK) || ((phase_next == PH_SEC) && (tdc_next != 2'd0));
        day_ok  = (ndc_next >= NDC_W'(1)) && (ndc_next <= NDC_W'(2));
        year_ok = (ndc_next >= NDC_W'(2)) && (ndc_next <= NDC_W'(4));
        mon     = (tpos_next == 2'd3) ? month_code(letters_next) : '0;
        if ((is_delim(c) || in_last_reg) && in_tok_next) begin
            if (!found_reg[FND_TIME] && time_ok) begin
                found_next[FND_TIME] = 1'b1;
            end else if (!found_reg[FND_DAY] && day_ok) begin
                found_next[FND_DAY] = 1'b1;
                day_next            = acc_next[VAL_W-1:0];
            end else if (!found_reg[FND_MONTH] && (mon != '0)) begin
                found_next[FND_MONTH] = 1'b1;
                month_next            = mon;
            end else if (!found_reg[FND_YEAR] && year_ok) begin
                found_next[FND_YEAR] = 1'b1;
                year_next            = acc_next;
            end
            tpos_next    = '0;
            in_tok_next  = 1'b0;
            phase_next   = PH_HOUR;
            tdc_next     = '0;
            acc_next     = '0;
            ndc_next     = '0;
            nstop_next   = 1'b0;
            letters_next = '0;
        end

        // final check
        if (year_next < YEAR_TWO_LIM) begin
            yfix = year_next + ((year_next < YEAR_PIVOT) ? YEAR_BASE_20 : YEAR_BASE_19);
        end else begin
            yfix = year_next;
        end
        ok = (found_next == 4'hF) && (day_next >= VAL_W'(1)) && (day_next <= VAL_W'(31))
          && (yfix >= YEAR_MIN) && (hour_next <= VAL_W'(23))
          && (minute_next <= VAL_W'(59)) && (second_next <= VAL_W'(59));
        out_data_next = '0;
        if (ok) begin
            out_data_next = {7'b0, second_next[5:0], minute_next[5:0], hour_next[4:0],
                             day_next[4:0], month_next, yfix, 1'b1};
        end

        // string done: back to the reset state
        if (in_last_reg) begin
            found_next  = '0;
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
            day_next    = '0;
            month_next  = '0;
            year_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            in_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
            tpos_reg      <= '0;
            in_tok_reg    <= 1'b0;
            phase_reg     <= PH_HOUR;
            tdc_reg       <= '0;
            acc_reg       <= '0;
            ndc_reg       <= '0;
            nstop_reg     <= 1'b0;
            letters_reg   <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (s_tvalid && s_tready) begin
                in_last_reg <= s_tlast;
            end
            if (advance) begin
                found_reg   <= found_next;
                hour_reg    <= hour_next;
                minute_reg  <= minute_next;
                second_reg  <= second_next;
                day_reg     <= day_next;
                month_reg   <= month_next;
                year_reg    <= year_next;
                tpos_reg    <= tpos_next;
                in_tok_reg  <= in_tok_next;
                phase_reg   <= phase_next;
                tdc_reg     <= tdc_next;
                acc_reg     <= acc_next;
                ndc_reg     <= ndc_next;
                nstop_reg   <= nstop_next;
                letters_reg <= letters_next;
            end
            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
        end
        if (advance && in_last_reg) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTH
    // a valid date always carries a month from the name table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[0]) |->
            ((out_data_reg[18:15] != 4'd0) && (out_data_reg[18:15] <= 4'd12)))
        else $error("valid date with month out of range");

    // an invalid date has all fields zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_data_reg[0]) |-> (out_data_reg == '0))
        else $error("invalid date with nonzero fields");

    // the parser starts fresh after each string
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> ((found_reg == '0) && !in_tok_reg && (acc_reg == '0)))
        else $error("parse state not cleared after last byte");
`endif

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the cookie date parser: random date strings against a shadow parser.
`timescale 1ns / 1ps
module tb_top;
    import cdtp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 10;
    // lowercase month prefixes, "jan" in the top bits
    localparam logic [12*24-1:0] MONTH_TAGS = "janfebmaraprmayjunjulaugsepoctnovdec";

    typedef enum {TK_TIME, TK_DAY, TK_MONTH, TK_YEAR, TK_NOISE} tok_kind_t;

    // result item as it sits in m_tdata, date_valid in bit 0
    typedef struct packed {
        logic [6:0]  pad;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        valid;
    } date_rec_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_IN-1:0]  s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_OUT-1:0] m_tdata;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned errors        = 0;
    int unsigned bytes_sent    = 0;
    int unsigned stall_cycles  = 0;

    date_rec_t   expected_dates[$];
    logic [7:0]  line_buf[$];

    // shadow parser state
    logic [3:0]  seen_kinds;
    logic [6:0]  hr_val, mn_val, sc_val, dom_val;
    logic [3:0]  mon_val;
    logic [13:0] yr_val;
    logic [1:0]  tok_len;
    logic        tok_open;
    logic [2:0]  clock_phase;
    logic [1:0]  clock_digits;
    logic [13:0] lead_num;
    logic [2:0]  lead_digits;
    logic        lead_done;
    logic [23:0] tok_prefix;

    cookie_date_token_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // ---------------- shadow parser ----------------

    function automatic logic is_delimiter(input logic [7:0] c);
        return (c == 8'h09) || (c >= 8'h20 && c <= 8'h2F) || (c >= 8'h3B && c <= 8'h40)
            || (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    function automatic logic [3:0] month_of(input logic [23:0] w, input logic [1:0] len);
        logic [3:0] m;
        m = 4'd0;
        if (len == 2'd3) begin
            for (int i = 0; i < 12; i++) begin
                if (MONTH_TAGS[(11 - i) * 24 +: 24] == w) m = 4'(i + 1);
            end
        end
        return m;
    endfunction

    task automatic token_clear();
        tok_len      = '0;
        tok_open     = 1'b0;
        clock_phase  = PH_HOUR;
        clock_digits = '0;
        lead_num     = '0;
        lead_digits  = '0;
        lead_done    = 1'b0;
        tok_prefix   = '0;
    endtask

    task automatic parser_reset();
        seen_kinds = '0;
        hr_val     = '0;
        mn_val     = '0;
        sc_val     = '0;
        dom_val    = '0;
        mon_val    = '0;
        yr_val     = '0;
        token_clear();
    endtask

    task automatic take_token_byte(input logic [7:0] c);
        logic       dig;
        logic [3:0] d;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d   = c[3:0];
        tok_open = 1'b1;
        if (tok_len < 2'd3) begin
            tok_prefix = {tok_prefix[15:0], (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c};
            tok_len++;
        end
        if (!lead_done) begin
            if (dig) begin
                if (lead_digits < 3'd5) lead_digits++;
                if (lead_digits <= 3'd4) lead_num = 14'(lead_num * 10 + d);
            end else begin
                lead_done = 1'b1;
            end
        end
        // time field walk, only until a time has been taken
        if (!seen_kinds[FND_TIME] && clock_phase < PH_OK) begin
            if (dig) begin
                if (clock_digits >= 2'd2) begin
                    clock_phase = PH_FAIL;
                end else begin
                    case (clock_phase)
                        PH_HOUR: hr_val = (clock_digits == 0) ? 7'(d) : 7'(hr_val * 10 + d);
                        PH_MIN:  mn_val = (clock_digits == 0) ? 7'(d) : 7'(mn_val * 10 + d);
                        default: sc_val = (clock_digits == 0) ? 7'(d) : 7'(sc_val * 10 + d);
                    endcase
                    clock_digits++;
                end
            end else if (clock_digits == 0) begin
                clock_phase = PH_FAIL;
            end else if (clock_phase == PH_SEC) begin
                clock_phase = PH_OK;
            end else if (c == CH_COLON) begin
                clock_phase++;
                clock_digits = '0;
            end else begin
                clock_phase = PH_FAIL;
            end
        end
    endtask

    task automatic close_token();
        logic       time_ok, day_ok, year_ok;
        logic [3:0] m;
        time_ok = (clock_phase == PH_OK) || (clock_phase == PH_SEC && clock_digits != 0);
        day_ok  = (lead_digits >= 3'd1) && (lead_digits <= 3'd2);
        year_ok = (lead_digits >= 3'd2) && (lead_digits <= 3'd4);
        m       = month_of(tok_prefix, tok_len);
        if (tok_open) begin
            if (!seen_kinds[FND_TIME] && time_ok) begin
                seen_kinds[FND_TIME] = 1'b1;
            end else if (!seen_kinds[FND_DAY] && day_ok) begin
                seen_kinds[FND_DAY] = 1'b1;
                dom_val = lead_num[6:0];
            end else if (!seen_kinds[FND_MONTH] && m != 0) begin
                seen_kinds[FND_MONTH] = 1'b1;
                mon_val = m;
            end else if (!seen_kinds[FND_YEAR] && year_ok) begin
                seen_kinds[FND_YEAR] = 1'b1;
                yr_val = lead_num;
            end
            token_clear();
        end
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic last);
        date_rec_t   r;
        logic [13:0] y;
        logic        ok;
        if (is_delimiter(c)) close_token();
        else take_token_byte(c);
        if (last) begin
            close_token();
            y = yr_val;
            if (y < YEAR_TWO_LIM) y = y + ((y < YEAR_PIVOT) ? YEAR_BASE_20 : YEAR_BASE_19);
            ok = (seen_kinds == 4'hF) && (dom_val >= 1) && (dom_val <= 31) && (y >= YEAR_MIN)
                && (hr_val <= 23) && (mn_val <= 59) && (sc_val <= 59);
            r = '0;
            if (ok) begin
                r.valid  = 1'b1;
                r.year   = y;
                r.month  = mon_val;
                r.day    = dom_val[4:0];
                r.hour   = hr_val[4:0];
                r.minute = mn_val[5:0];
                r.second = sc_val[5:0];
            end
            expected_dates.push_back(r);
            parser_reset();
        end
    endtask

    // ---------------- checking ----------------

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        date_rec_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_dates.size() == 0) begin
                errors++;
                $display("%0t: result item with none expected, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want = expected_dates.pop_front();
                check_field("date_valid", 32'(want.valid),  32'(got.valid));
                check_field("year_out",   32'(want.year),   32'(got.year));
                check_field("month_out",  32'(want.month),  32'(got.month));
                check_field("day_out",    32'(want.day),    32'(got.day));
                check_field("hour_out",   32'(want.hour),   32'(got.hour));
                check_field("minute_out", 32'(want.minute), 32'(got.minute));
                check_field("second_out", 32'(want.second), 32'(got.second));
                check_field("tdata pad",  32'(want.pad),    32'(got.pad));
            end
        end
    end

    // cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no item moved for %0d cycles", $time, stall_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------

    // called at a falling edge, returns at a falling edge; valid is left high
    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_byte(c, last);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic load_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_dates.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic put_number(input int unsigned v, input int unsigned nd);
        int unsigned scale;
        scale = 1;
        repeat (nd - 1) scale *= 10;
        repeat (nd) begin
            line_buf.push_back(8'(8'h30 + (v / scale) % 10));
            scale /= 10;
        end
    endtask

    task automatic put_delims();
        repeat ($urandom_range(2, 1)) begin
            case ($urandom_range(7, 0))
                0:       line_buf.push_back(8'h09);
                1:       line_buf.push_back(8'($urandom_range(8'h2F, 8'h20)));
                2:       line_buf.push_back(8'($urandom_range(8'h40, 8'h3B)));
                3:       line_buf.push_back(8'($urandom_range(8'h60, 8'h5B)));
                4:       line_buf.push_back(8'($urandom_range(8'h7E, 8'h7B)));
                default: line_buf.push_back(8'h20);
            endcase
        end
    endtask

    task automatic put_token(input tok_kind_t k);
        int unsigned v, nd, nf, m;
        logic [7:0]  ch;
        case (k)
            TK_TIME: begin
                // mostly h:m:s in range; some short, three-digit or badly separated
                nf = ($urandom_range(9, 0) == 0) ? 2 : 3;
                for (int f = 0; f < nf; f++) begin
                    v  = ($urandom_range(7, 0) == 0) ? $urandom_range(99, 0)
                                                     : $urandom_range(f == 0 ? 23 : 59, 0);
                    nd = (v > 9) ? 2 : $urandom_range(2, 1);
                    if ($urandom_range(15, 0) == 0) nd = 3;
                    put_number(v, nd);
                    if (f < nf - 1) begin
                        case ($urandom_range(19, 0))
                            0:       line_buf.push_back("x");
                            1:       line_buf.push_back(".");
                            default: line_buf.push_back(CH_COLON);
                        endcase
                    end
                end
                if ($urandom_range(5, 0) == 0) line_buf.push_back("Z");
            end
            TK_DAY: begin
                v  = ($urandom_range(7, 0) == 0) ? $urandom_range(99, 0) : $urandom_range(31, 1);
                nd = (v > 9) ? 2 : $urandom_range(2, 1);
                if ($urandom_range(11, 0) == 0) nd = 3;
                put_number(v, nd);
                if ($urandom_range(7, 0) == 0) line_buf.push_back("h");
            end
            TK_MONTH: begin
                m = $urandom_range(11, 0);
                case ($urandom_range(9, 0))
                    0:       nd = 2;
                    1:       nd = $urandom_range(6, 4);
                    default: nd = 3;
                endcase
                for (int i = 0; i < nd; i++) begin
                    ch = (i < 3) ? MONTH_TAGS[(11 - m) * 24 + (2 - i) * 8 +: 8]
                                 : 8'($urandom_range("z", "a"));
                    if ($urandom_range(1, 0) == 1) ch = ch - CASE_OFS;
                    if ($urandom_range(15, 0) == 0) ch = ch ^ 8'h01;
                    line_buf.push_back(ch);
                end
            end
            TK_YEAR: begin
                case ($urandom_range(9, 0))
                    0:       nd = 1;
                    1:       nd = 3;
                    2:       nd = 5;
                    3, 4, 5: nd = 2;
                    default: nd = 4;
                endcase
                v = (nd == 4) ? $urandom_range(9999, 1550) : $urandom_range(10 ** nd - 1, 0);
                put_number(v, nd);
            end
            default: begin
                // any non-delimiter bytes: high bytes, control bytes, digits, letters
                repeat ($urandom_range(4, 1)) begin
                    do ch = 8'($urandom_range(255, 0)); while (is_delimiter(ch));
                    line_buf.push_back(ch);
                end
            end
        endcase
    endtask

    task automatic build_date_line();
        tok_kind_t   order [5];
        tok_kind_t   t;
        int unsigned n, j;
        line_buf.delete();
        // occasional raw garbage line
        if ($urandom_range(9, 0) == 0) begin
            repeat ($urandom_range(8, 1)) line_buf.push_back(8'($urandom_range(255, 0)));
            return;
        end
        order = '{TK_TIME, TK_DAY, TK_MONTH, TK_YEAR, TK_NOISE};
        n = ($urandom_range(4, 0) == 0) ? 5 : 4;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(i, 0);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        if ($urandom_range(3, 0) == 0) put_delims();
        for (int i = 0; i < n; i++) begin
            if (i > 0) put_delims();
            put_token(order[i]);
        end
        if ($urandom_range(3, 0) == 0) put_delims();
    endtask

    // ---------------- tests ----------------

    task automatic test_extremes();
        load_text("23:59:59 31 DEC 9999");
        send_line();
        load_text(" ");                    // delimiter-only string
        send_line();
        line_buf = '{8'h00, 8'hFF};        // control byte then high byte
        send_line();
    endtask

    // one-byte strings back to back, so results pile up against a stalled receiver
    task automatic test_short_lines();
        repeat (40) begin
            line_buf = '{8'($urandom_range(255, 0))};
            send_line();
        end
    endtask

    task automatic test_random_dates(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_bytes);
        int unsigned start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            build_date_line();
            send_line();
        end
    endtask

    initial begin
        parser_reset();
        send_idle_pct = 21;
        recv_idle_pct = 66;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_extremes();
        test_short_lines();
        test_random_dates(21, 66, 420);
        wait_results_drained();            // sender holds off until all results are in
        test_random_dates(66, 21, 420);
        wait_results_drained();
        test_random_dates(0, 0, 420);
        wait_results_drained();

        if (errors == 0 && expected_dates.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* cookie_date_token_parser.f */
design/cdtp_pkg.sv
design/cookie_date_token_parser.sv
bench/tb_top.sv
